// ----- design/hrf_pkg.sv -----
// Package: shared types, constants and character helpers of the HTTP request framer.
`timescale 1ns / 1ps
package hrf_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int TOTAL_BITS  = LENGTH_BITS + 1;

  // room for a length times sixteen plus one digit
  typedef logic [LENGTH_BITS+3:0] len_ext_t;

  localparam logic [LENGTH_BITS-1:0] LEN_CAP   = {LENGTH_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0]  TOTAL_CAP = {TOTAL_BITS{1'b1}};

  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;
  localparam logic [15:0] MAX_URI_RESET  = 16'd8192;

  // register indexes
  localparam logic REG_MAX_BODY = 1'b0;
  localparam logic REG_MAX_URI  = 1'b1;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_REQ   = 3'd1;
  localparam logic [2:0] ERR_VERSION   = 3'd2;
  localparam logic [2:0] ERR_URI_LONG  = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

  // header name flags
  localparam logic [2:0] NF_TE  = 3'b001;
  localparam logic [2:0] NF_CL  = 3'b010;
  localparam logic [2:0] NF_VAL = 3'b100;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [7:0] {
    PH_REQ   = 8'b0000_0001,
    PH_HDR   = 8'b0000_0010,
    PH_BODY  = 8'b0000_0100,
    PH_CSIZE = 8'b0000_1000,
    PH_CDATA = 8'b0001_0000,
    PH_CCRLF = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_ERR   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   cr_seen;
    logic [1:0]             token_index;
    logic                   in_token;
    logic [16:0]            uri_count;
    logic [3:0]             version_match;
    logic                   line_empty;
    logic [4:0]             name_index;
    logic [2:0]             name_flags;
    logic [2:0]             chunked_match;
    logic                   chunked_flag;
    logic [LENGTH_BITS-1:0] length_value;
    logic                   length_seen;
    logic [LENGTH_BITS-1:0] remaining;
    logic [TOTAL_BITS-1:0]  body_total;
    logic                   hex_stopped;
    logic [1:0]             skip_count;
    logic [2:0]             error_state;
  } parse_st_t;

  typedef struct packed {
    logic [31:0] body_length;
    logic        chunked_body;
    logic [2:0]  error_code;
    logic        failed;
    logic        complete;
    logic        body_valid;
    logic [7:0]  body_byte;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

  // 16 means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] lc;
    lc = to_lower(c);
    if ((c >= 8'h30) && (c <= 8'h39)) return 5'(c - 8'h30);
    if ((lc >= 8'h61) && (lc <= 8'h66)) return 5'(lc - 8'h61 + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [7:0] ver_char(input logic [3:0] i);
    case (i)
      4'd0: return 8'h48; // H
      4'd1: return 8'h54; // T
      4'd2: return 8'h54; // T
      4'd3: return 8'h50; // P
      4'd4: return 8'h2F; // /
      4'd5: return 8'h31; // 1
      4'd6: return 8'h2E; // .
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    case (i)
      5'd0:  return 8'h74; 5'd1:  return 8'h72; 5'd2:  return 8'h61;
      5'd3:  return 8'h6E; 5'd4:  return 8'h73; 5'd5:  return 8'h66;
      5'd6:  return 8'h65; 5'd7:  return 8'h72; 5'd8:  return 8'h2D;
      5'd9:  return 8'h65; 5'd10: return 8'h6E; 5'd11: return 8'h63;
      5'd12: return 8'h6F; 5'd13: return 8'h64; 5'd14: return 8'h69;
      5'd15: return 8'h6E; 5'd16: return 8'h67;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    case (i)
      5'd0:  return 8'h63; 5'd1:  return 8'h6F; 5'd2:  return 8'h6E;
      5'd3:  return 8'h74; 5'd4:  return 8'h65; 5'd5:  return 8'h6E;
      5'd6:  return 8'h74; 5'd7:  return 8'h2D; 5'd8:  return 8'h6C;
      5'd9:  return 8'h65; 5'd10: return 8'h6E; 5'd11: return 8'h67;
      5'd12: return 8'h74; 5'd13: return 8'h68;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ck_char(input logic [2:0] i);
    case (i)
      3'd0: return 8'h63; 3'd1: return 8'h68; 3'd2: return 8'h75;
      3'd3: return 8'h6E; 3'd4: return 8'h6B; 3'd5: return 8'h65;
      3'd6: return 8'h64;
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ----- design/http_request_framer_core.sv -----
// Top level: byte-serial HTTP/1.x request framer and body decoder.
`timescale 1ns / 1ps
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tdata: data_byte; tuser: new_request
//  out_    | out | out_tvalid / out_tready| tdata: body byte, flags, code, length
//  cfg_    | in  | cfg_we                 | cfg_addr selects register, cfg_wdata
//
// One item a cycle while in_tready is high: the step logic updates the parse
// state per accepted byte; its result lands in the output or skid register.
// A skid register behind the output lets one more item in while out_tready is
// low; in_tready drops only while that skid register is full.
// Reset (synchronous, rst_n low) clears parse state and loads register defaults.
module http_request_framer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] new_request
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] body_byte, [8] body_valid, [9] complete, [10] failed,
  // [13:11] error_code, [14] chunked_body, [46:15] body_length, [47] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  hrf_pkg::parse_st_t st_r, st_nxt;
  hrf_pkg::result_t   res_nxt, out_data_r, skid_data_r;
  logic               out_vld_r, skid_vld_r;
  logic [31:0]        max_body_r;
  logic [15:0]        max_uri_r;
  logic               acc;

  // Per-line state back to its start.
  function automatic hrf_pkg::parse_st_t line_clear(input hrf_pkg::parse_st_t s);
    hrf_pkg::parse_st_t t;
    t = s;
    t.cr_seen = 1'b0; t.line_empty = 1'b1; t.token_index = 2'd0; t.in_token = 1'b0;
    t.name_index = 5'd0; t.name_flags = hrf_pkg::NF_TE | hrf_pkg::NF_CL;
    t.chunked_match = 3'd0; t.remaining = '0; t.hex_stopped = 1'b0;
    return t;
  endfunction

  function automatic hrf_pkg::parse_st_t clear_parse(input hrf_pkg::parse_st_t s);
    hrf_pkg::parse_st_t t;
    t = line_clear(s);
    t.name_flags = 3'd0; t.phase = hrf_pkg::PH_REQ; t.uri_count = 17'd0;
    t.version_match = 4'd0; t.chunked_flag = 1'b0; t.length_value = '0;
    t.length_seen = 1'b0; t.body_total = '0; t.skip_count = 2'd0;
    t.error_state = hrf_pkg::ERR_NONE;
    return t;
  endfunction

  // Request-line byte: count tokens, measure the target, match the version.
  function automatic hrf_pkg::parse_st_t rl_char(input hrf_pkg::parse_st_t s,
                                                 input logic [7:0] c);
    hrf_pkg::parse_st_t t;
    logic ok;
    t = s;
    ok = 1'b0;
    if (hrf_pkg::is_ws(c)) begin
      if (t.in_token) begin
        t.in_token = 1'b0;
        if (t.token_index == 2'd3 && t.version_match <= 4'd8)
          t.version_match = (t.version_match == 4'd8) ? 4'd9 : 4'd15;
      end
    end else begin
      if (!t.in_token) begin
        t.in_token = 1'b1;
        if (t.token_index < 2'd3) t.token_index = t.token_index + 2'd1;
      end
      if (t.token_index == 2'd2) begin
        if (t.uri_count != 17'h1FFFF) t.uri_count = t.uri_count + 17'd1;
      end else if (t.token_index == 2'd3 && t.version_match < 4'd9) begin
        if (t.version_match == 4'd8) ok = 1'b0;
        else if (t.version_match == 4'd7) ok = (c == 8'h30) || (c == 8'h31);
        else ok = (c == hrf_pkg::ver_char(t.version_match));
        t.version_match = ok ? t.version_match + 4'd1 : 4'd15;
      end
    end
    return t;
  endfunction

  // Header byte: match the name, then look for chunked or read decimal digits.
  function automatic hrf_pkg::parse_st_t hd_char(input hrf_pkg::parse_st_t s,
                                                 input logic [7:0] c);
    hrf_pkg::parse_st_t t;
    logic [7:0] lc;
    logic [2:0] keep;
    hrf_pkg::len_ext_t prod;
    t = s;
    lc = hrf_pkg::to_lower(c);
    keep = hrf_pkg::NF_VAL;
    prod = '0;
    if ((t.name_flags & hrf_pkg::NF_VAL) == 3'd0) begin
      if (c == hrf_pkg::CH_COLON) begin
        if ((t.name_flags & hrf_pkg::NF_TE) != 3'd0 && t.name_index == 5'd17)
          keep = keep | hrf_pkg::NF_TE;
        if ((t.name_flags & hrf_pkg::NF_CL) != 3'd0 && t.name_index == 5'd14)
          keep = keep | hrf_pkg::NF_CL;
        t.name_flags = keep;
      end else if (hrf_pkg::is_ws(c)) begin
        if (t.name_index > 5'd0) t.in_token = 1'b1;
      end else if (t.in_token) begin
        t.name_flags = t.name_flags & ~(hrf_pkg::NF_TE | hrf_pkg::NF_CL);
      end else begin
        if (t.name_index >= 5'd17 || lc != hrf_pkg::te_char(t.name_index))
          t.name_flags = t.name_flags & ~hrf_pkg::NF_TE;
        if (t.name_index >= 5'd14 || lc != hrf_pkg::cl_char(t.name_index))
          t.name_flags = t.name_flags & ~hrf_pkg::NF_CL;
        if (t.name_index < 5'd31) t.name_index = t.name_index + 5'd1;
      end
    end else begin
      if ((t.name_flags & hrf_pkg::NF_TE) != 3'd0 && t.chunked_match < 3'd7)
        t.chunked_match = (lc == hrf_pkg::ck_char(t.chunked_match)) ?
                          t.chunked_match + 3'd1 : ((lc == 8'h63) ? 3'd1 : 3'd0);
      if ((t.name_flags & hrf_pkg::NF_CL) != 3'd0) begin
        if (!(hrf_pkg::is_ws(c) && !t.hex_stopped)) begin
          t.hex_stopped = 1'b1;
          if (t.token_index == 2'd0) begin
            if (c >= 8'h30 && c <= 8'h39) begin
              prod = (hrf_pkg::len_ext_t'(t.remaining) << 3)
                     + (hrf_pkg::len_ext_t'(t.remaining) << 1)
                     + hrf_pkg::len_ext_t'(c - 8'h30);
              t.remaining = (prod > hrf_pkg::len_ext_t'(hrf_pkg::LEN_CAP)) ?
                            hrf_pkg::LEN_CAP : prod[hrf_pkg::LENGTH_BITS-1:0];
            end else begin
              t.token_index = 2'd1;
            end
          end
        end
      end
    end
    return t;
  endfunction

  // Chunk size byte: hex digits after optional leading whitespace.
  function automatic hrf_pkg::parse_st_t sz_char(input hrf_pkg::parse_st_t s,
                                                 input logic [7:0] c);
    hrf_pkg::parse_st_t t;
    logic [4:0] d;
    hrf_pkg::len_ext_t prod;
    t = s;
    d = hrf_pkg::hex_val(c);
    prod = '0;
    if (!t.hex_stopped) begin
      if (d < 5'd16) begin
        prod = (hrf_pkg::len_ext_t'(t.remaining) << 4) + hrf_pkg::len_ext_t'(d);
        t.remaining = (prod > hrf_pkg::len_ext_t'(hrf_pkg::LEN_CAP)) ?
                      hrf_pkg::LEN_CAP : prod[hrf_pkg::LENGTH_BITS-1:0];
        t.token_index = 2'd1;
      end else if (!(hrf_pkg::is_ws(c) && t.token_index == 2'd0)) begin
        t.hex_stopped = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic hrf_pkg::parse_st_t content(input hrf_pkg::parse_st_t s,
                                                 input logic [7:0] c);
    hrf_pkg::parse_st_t t;
    t = s;
    t.line_empty = 1'b0;
    if (t.phase == hrf_pkg::PH_REQ) t = rl_char(t, c);
    else if (t.phase == hrf_pkg::PH_HDR) t = hd_char(t, c);
    else t = sz_char(t, c);
    return t;
  endfunction

  // Line end: check the request line, latch header results, or close a size line.
  function automatic hrf_pkg::parse_st_t line_end(input hrf_pkg::parse_st_t s,
                                                  input logic [31:0] max_body,
                                                  input logic [15:0] max_uri);
    hrf_pkg::parse_st_t t;
    t = s;
    if (t.phase == hrf_pkg::PH_REQ) begin
      if (t.token_index != 2'd3) begin
        t.phase = hrf_pkg::PH_ERR; t.error_state = hrf_pkg::ERR_BAD_REQ;
      end else if (t.version_match != 4'd8 && t.version_match != 4'd9) begin
        t.phase = hrf_pkg::PH_ERR; t.error_state = hrf_pkg::ERR_VERSION;
      end else if (t.uri_count > {1'b0, max_uri}) begin
        t.phase = hrf_pkg::PH_ERR; t.error_state = hrf_pkg::ERR_URI_LONG;
      end else begin
        t = line_clear(t);
        t.phase = hrf_pkg::PH_HDR;
      end
    end else if (t.phase == hrf_pkg::PH_HDR) begin
      if (t.line_empty) begin
        if (t.chunked_flag) begin
          t = line_clear(t);
          t.phase = hrf_pkg::PH_CSIZE;
        end else if (t.length_seen) begin
          if (max_body != 32'd0 && t.length_value > max_body) begin
            t.phase = hrf_pkg::PH_ERR; t.error_state = hrf_pkg::ERR_TOO_LARGE;
          end else if (t.length_value == '0) begin
            t.phase = hrf_pkg::PH_DONE;
          end else begin
            t.remaining = t.length_value;
            t.phase = hrf_pkg::PH_BODY;
          end
        end else begin
          t.phase = hrf_pkg::PH_DONE;
        end
      end else begin
        if ((t.name_flags & hrf_pkg::NF_VAL) != 3'd0) begin
          if ((t.name_flags & hrf_pkg::NF_TE) != 3'd0)
            t.chunked_flag = (t.chunked_match == 3'd7);
          if ((t.name_flags & hrf_pkg::NF_CL) != 3'd0) begin
            t.length_seen = t.hex_stopped;
            t.length_value = t.remaining;
          end
        end
        t = line_clear(t);
      end
    end else begin
      t.phase = (t.remaining == '0) ? hrf_pkg::PH_DONE : hrf_pkg::PH_CDATA;
    end
    return t;
  endfunction

  assign acc        = in_tvalid & in_tready;
  assign in_tready  = ~skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_data_r};

  // Step logic: one byte through the parser.
  always_comb begin
    hrf_pkg::parse_st_t s;
    logic [7:0] b;
    logic       valid;
    logic       done;
    b     = in_tdata;
    valid = 1'b0;
    done  = 1'b0;
    s     = st_r;
    if (in_tuser) s = clear_parse(s);
    case (s.phase)
      hrf_pkg::PH_REQ, hrf_pkg::PH_HDR, hrf_pkg::PH_CSIZE: begin
        if (b == hrf_pkg::CH_LF && s.cr_seen) begin
          s.cr_seen = 1'b0;
          s = line_end(s, max_body_r, max_uri_r);
        end else begin
          // a CR not followed by LF is plain whitespace
          if (s.cr_seen) s = content(s, hrf_pkg::CH_CR);
          if (b == hrf_pkg::CH_CR) begin
            s.cr_seen = 1'b1;
          end else begin
            s.cr_seen = 1'b0;
            s = content(s, b);
          end
        end
      end
      hrf_pkg::PH_BODY: begin
        valid = 1'b1;
        s.remaining = s.remaining - 1'b1;
        if (s.remaining == '0) s.phase = hrf_pkg::PH_DONE;
      end
      hrf_pkg::PH_CDATA: begin
        if (s.body_total != hrf_pkg::TOTAL_CAP) s.body_total = s.body_total + 1'b1;
        if (max_body_r != 32'd0 && s.body_total > {1'b0, max_body_r}) begin
          s.phase = hrf_pkg::PH_ERR;
          s.error_state = hrf_pkg::ERR_TOO_LARGE;
        end else begin
          valid = 1'b1;
          s.remaining = s.remaining - 1'b1;
          if (s.remaining == '0) begin
            s.skip_count = 2'd2;
            s.phase = hrf_pkg::PH_CCRLF;
          end
        end
      end
      hrf_pkg::PH_CCRLF: begin
        // drop the two bytes after each chunk's data
        if (s.skip_count != 2'd0) s.skip_count = s.skip_count - 2'd1;
        if (s.skip_count == 2'd0) begin
          s = line_clear(s);
          s.phase = hrf_pkg::PH_CSIZE;
        end
      end
      default: begin
      end
    endcase
    st_nxt = s;

    done = (s.phase == hrf_pkg::PH_DONE);
    res_nxt.body_byte    = valid ? b : 8'd0;
    res_nxt.body_valid   = valid;
    res_nxt.complete     = done;
    res_nxt.failed       = (s.phase == hrf_pkg::PH_ERR);
    res_nxt.error_code   = s.error_state;
    res_nxt.chunked_body = s.chunked_flag && s.phase != hrf_pkg::PH_REQ &&
                           s.phase != hrf_pkg::PH_HDR;
    res_nxt.body_length  = 32'd0;
    if (s.phase != hrf_pkg::PH_REQ && s.phase != hrf_pkg::PH_HDR) begin
      if (s.chunked_flag) begin
        if (done)
          res_nxt.body_length = s.body_total[hrf_pkg::TOTAL_BITS-1] ?
                                32'hFFFF_FFFF : s.body_total[31:0];
      end else if (s.length_seen) begin
        res_nxt.body_length = s.length_value;
      end
    end
  end

  // Parse state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= clear_parse('0);
      max_body_r <= hrf_pkg::MAX_BODY_RESET;
      max_uri_r  <= hrf_pkg::MAX_URI_RESET;
    end else begin
      if (acc) st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          hrf_pkg::REG_MAX_BODY: max_body_r <= cfg_wdata;
          hrf_pkg::REG_MAX_URI:  max_uri_r  <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Output register and skid control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_tready) begin
      if (acc) skid_vld_r <= 1'b1;
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_tready) begin
      if (acc) skid_data_r <= res_nxt;
    end else if (skid_vld_r) begin
      out_data_r <= skid_data_r;
    end else if (acc) begin
      out_data_r <= res_nxt;
    end
  end

  // A full skid register always sits behind a valid output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r) else $error("skid full with output empty");

  // A stalled output keeps its item, also when the skid register fills.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_data_r)))
    else $error("stalled item lost");

  // Body bytes are never passed out with the failed flag or an error code set.
  a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.body_valid) |->
    (!out_data_r.failed && out_data_r.error_code == hrf_pkg::ERR_NONE))
    else $error("body byte with error");

endmodule
